[hdl/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, codes and the byte-wide CRC-16/CCITT-FALSE step for the
// frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // register indexes (byte address / 4)
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // entries in the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // frame status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_BAD_MAGIC   = 3'd3,
    ST_BAD_VERSION = 3'd4,
    ST_BAD_CRC     = 3'd5
  } status_e;

  // per-frame record handed from front to back
  typedef struct packed {
    logic        too_short;
    logic        too_long;
    logic        magic_bad;
    logic        version_bad;
    logic [7:0]  data_len;     // already zero when length is invalid
    logic [15:0] crc;          // computed over all but the trailer
    logic [15:0] want;         // received trailer, little endian
  } frame_rec_t;

  // one byte through the CRC, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/fcc_front.sv]
// ----------------------------------------------------------------------------
// fcc_front
// Takes frame bytes, runs the CRC behind a two-byte delay, counts bytes and
// checks the header. At the last byte it emits one frame record.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_front #(
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned FRAME_MAX_BYTES = 250
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               acc_i,          // byte accepted this cycle
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_i,
  input  wire logic [31:0]        magic_word_i,
  input  wire logic [7:0]         protocol_version_i,
  output      logic               rec_valid_o,
  output      fcc_pkg::frame_rec_t rec_o
);
  import fcc_pkg::*;

  localparam int unsigned CntW = $clog2(FRAME_MAX_BYTES + 2);
  localparam int unsigned ExtW = (CntW > 8) ? CntW : 8;

  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     dly_q, dly_d;
  logic            magic_bad_q, magic_bad_d;
  logic            version_bad_q, version_bad_d;

  logic [15:0]     crc_nxt;
  logic [CntW-1:0] cnt_nxt;
  logic            magic_bad_nxt, version_bad_nxt;
  logic [7:0]      magic_byte;
  logic [ExtW-1:0] len_x, plen_x;
  logic            too_short, too_long;

  // expected magic byte for the current position
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    magic_byte = magic_word_i[7:0];
      2'd1:    magic_byte = magic_word_i[15:8];
      2'd2:    magic_byte = magic_word_i[23:16];
      default: magic_byte = magic_word_i[31:24];
    endcase
  end

  // per-byte update
  always_comb begin
    crc_nxt = (cnt_q >= CntW'(2)) ? crc_byte(crc_q, dly_q[15:8]) : crc_q;
    cnt_nxt = (cnt_q < CntW'(FRAME_MAX_BYTES + 1)) ? cnt_q + CntW'(1) : cnt_q;
    magic_bad_nxt   = magic_bad_q
                    | ((cnt_q < CntW'(4)) && (data_byte_i != magic_byte));
    version_bad_nxt = version_bad_q
                    | ((cnt_q == CntW'(4)) && (data_byte_i != protocol_version_i));
  end

  // length classification at the last byte
  always_comb begin
    len_x     = ExtW'(cnt_nxt);
    too_short = len_x < ExtW'(HEADER_BYTES + 2);
    too_long  = len_x > ExtW'(FRAME_MAX_BYTES);
    plen_x    = len_x - ExtW'(HEADER_BYTES + 2);
    rec_o.too_short   = too_short;
    rec_o.too_long    = too_long;
    rec_o.magic_bad   = magic_bad_nxt;
    rec_o.version_bad = version_bad_nxt;
    rec_o.crc         = crc_nxt;
    rec_o.want        = {data_byte_i, dly_q[7:0]};
    if (too_short || too_long) begin
      rec_o.data_len = 8'd0;
    end else if (plen_x > ExtW'(255)) begin
      rec_o.data_len = 8'hFF;
    end else begin
      rec_o.data_len = plen_x[7:0];
    end
    rec_valid_o = acc_i & last_i;
  end

  // next state: frame state reloads after the last byte
  always_comb begin
    crc_d         = crc_q;
    cnt_d         = cnt_q;
    dly_d         = dly_q;
    magic_bad_d   = magic_bad_q;
    version_bad_d = version_bad_q;
    if (acc_i) begin
      if (last_i) begin
        crc_d         = CRC_INIT;
        cnt_d         = '0;
        dly_d         = '0;
        magic_bad_d   = 1'b0;
        version_bad_d = 1'b0;
      end else begin
        crc_d         = crc_nxt;
        cnt_d         = cnt_nxt;
        dly_d         = {dly_q[7:0], data_byte_i};
        magic_bad_d   = magic_bad_nxt;
        version_bad_d = version_bad_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q         <= CRC_INIT;
      cnt_q         <= '0;
      dly_q         <= '0;
      magic_bad_q   <= 1'b0;
      version_bad_q <= 1'b0;
    end else begin
      crc_q         <= crc_d;
      cnt_q         <= cnt_d;
      dly_q         <= dly_d;
      magic_bad_q   <= magic_bad_d;
      version_bad_q <= version_bad_d;
    end
  end

endmodule

`default_nettype wire

[hdl/fcc_queue.sv]
// ----------------------------------------------------------------------------
// fcc_queue
// Short register queue of frame records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_i,
  input  wire fcc_pkg::frame_rec_t wdata_i,
  input  wire logic                rd_i,
  output      fcc_pkg::frame_rec_t rdata_o,
  output      logic                full_o,
  output      logic                empty_o
);
  import fcc_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  frame_rec_t      mem_q [QDEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PtrW'(QDEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PtrW'(QDEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[hdl/fcc_back.sv]
// ----------------------------------------------------------------------------
// fcc_back
// Resolves the frame status by priority and holds the result item in an
// output register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fcc_pkg::frame_rec_t rec_i,
  input  wire logic                rec_avail_i,
  output      logic                rec_take_o,
  input  wire logic                pop_i,
  output      logic                empty_o,
  output      logic [2:0]          status_o,
  output      logic [7:0]          data_len_o,
  output      logic [15:0]         crc_computed_o
);
  import fcc_pkg::*;

  logic        valid_q, valid_d;
  status_e     status_q, status_d;
  logic [7:0]  plen_q;
  logic [15:0] crc_q;

  // refill the output register when it is free or being drained
  assign rec_take_o = rec_avail_i && (!valid_q || pop_i);

  // status priority
  always_comb begin
    priority if (rec_i.too_short) begin
      status_d = ST_TOO_SHORT;
    end else if (rec_i.too_long) begin
      status_d = ST_TOO_LONG;
    end else if (rec_i.magic_bad) begin
      status_d = ST_BAD_MAGIC;
    end else if (rec_i.version_bad) begin
      status_d = ST_BAD_VERSION;
    end else if (rec_i.crc != rec_i.want) begin
      status_d = ST_BAD_CRC;
    end else begin
      status_d = ST_OK;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (rec_take_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result item, no reset
  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      status_q <= status_d;
      plen_q   <= rec_i.data_len;
      crc_q    <= rec_i.crc;
    end
  end

  assign empty_o        = !valid_q;
  assign status_o       = status_q;
  assign data_len_o     = plen_q;
  assign crc_computed_o = crc_q;

endmodule

`default_nettype wire

[hdl/frame_checker_crc16_unit.sv]
// ----------------------------------------------------------------------------
// frame_checker_crc16_unit
// Receive-side frame check: CRC-16/CCITT-FALSE over the frame less its
// little-endian trailer, header magic/version check and length check.
//
//   channel   direction  handshake         fields
//   bytes     in         push / full       data_byte_i, last_i
//   results   out        empty / pop       status_o, data_len_o,
//                                          crc_computed_o
//   config    in         APB psel/penable  magic_word (0x0), version (0x4)
//
// One byte is taken per cycle while full is low; the byte-wide CRC step in
// the front sets that. Each result passes the queue, then the output
// register. full rises only when the two-entry frame queue is full, which
// takes three results waiting while the result side stalls. Reset clears
// the frame state and both registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_checker_crc16_unit #(
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned FRAME_MAX_BYTES = 250
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  // result output
  output      logic        empty,
  input  wire logic        pop,
  output      logic [2:0]  status_o,
  output      logic [7:0]  data_len_o,
  output      logic [15:0] crc_computed_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import fcc_pkg::*;

  logic        acc;
  logic [31:0] magic_q, magic_d;
  logic [7:0]  version_q, version_d;
  logic        cfg_wr;
  logic        rec_valid, q_full, q_empty, q_rd;
  frame_rec_t  rec_in, rec_out;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    magic_d   = magic_q;
    version_d = version_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAGIC:   magic_d   = pwdata;
        REG_VERSION: version_d = pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAGIC:   prdata = magic_q;
      REG_VERSION: prdata = {24'h000000, version_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else begin
      magic_q   <= magic_d;
      version_q <= version_d;
    end
  end

  // input handshake
  assign full = q_full;
  assign acc  = push & ~q_full;

  fcc_front #(
    .HEADER_BYTES    (HEADER_BYTES),
    .FRAME_MAX_BYTES (FRAME_MAX_BYTES)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .acc_i              (acc),
    .data_byte_i        (data_byte_i),
    .last_i             (last_i),
    .magic_word_i       (magic_q),
    .protocol_version_i (version_q),
    .rec_valid_o        (rec_valid),
    .rec_o              (rec_in)
  );

  fcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_valid),
    .wdata_i (rec_in),
    .rd_i    (q_rd),
    .rdata_o (rec_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fcc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (rec_out),
    .rec_avail_i    (~q_empty),
    .rec_take_o     (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status_o),
    .data_len_o     (data_len_o),
    .crc_computed_o (crc_computed_o)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_checker_crc16_unit. A directed table of short
// frames and the minimum-length frame is walked first. It is followed by
// register phases of random frames. Most of these are well formed, carrying
// the magic, version and CRC trailer of the current setting. The others are
// damaged or pure noise. A byte-level tracker predicts each frame result, and
// every popped result is compared field by field with the oldest prediction.
// Both queue sides idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import fcc_pkg::*;

  localparam int unsigned HDR_LEN  = 16;
  localparam int unsigned FRM_MAX  = 250;
  localparam int unsigned N_ITEMS  = 1850;
  localparam int unsigned MAX_IDLE = 12;
  localparam int unsigned SETTLE   = 8;

  typedef struct packed {
    status_e     status;
    logic [7:0]  plen;
    logic [15:0] crc;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    frame_res_t res;
  } dir_row_t;

  localparam frame_res_t NO_RES = '{ST_OK, 8'd0, 16'h0000};

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        last_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [7:0]  data_len_o;
  logic [15:0] crc_computed_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // tracker copy of the frame state and the registers
  logic [31:0] cfg_magic;
  logic [7:0]  cfg_version;
  logic [15:0] trk_crc;
  int unsigned trk_count;
  logic [15:0] trk_delay;
  logic        trk_magic_bad;
  logic        trk_version_bad;

  frame_res_t  pending_res [$];
  int          errors;
  int          items_sent;
  int          frames_sent;
  int          results_seen;
  int          status_seen [6];
  int          settings_used;
  bit          tx_burst;
  bit          rx_burst;

  // short frames and the minimum-length frame after reset (magic 0, version 0)
  dir_row_t dir_rows [24] = '{
    '{8'hFF, 1'b1, 1'b1, '{ST_TOO_SHORT, 8'd0, 16'hFFFF}},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{ST_TOO_SHORT, 8'd0, 16'hFFFF}},
    '{8'hA5, 1'b0, 1'b0, NO_RES},
    '{8'h5A, 1'b0, 1'b0, NO_RES},
    '{8'h3C, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b0, NO_RES},
    '{8'hFE, 1'b0, 1'b0, NO_RES},
    '{8'h55, 1'b0, 1'b0, NO_RES},
    '{8'hAA, 1'b0, 1'b0, NO_RES},
    '{8'h0F, 1'b0, 1'b0, NO_RES},
    '{8'hF0, 1'b0, 1'b0, NO_RES},
    '{8'h33, 1'b0, 1'b0, NO_RES},
    '{8'hCC, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES}
  };

  frame_checker_crc16_unit #(
    .HEADER_BYTES   (HDR_LEN),
    .FRAME_MAX_BYTES(FRM_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .data_len_o    (data_len_o),
    .crc_computed_o(crc_computed_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    repeat (8) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  function automatic void clear_frame();
    trk_crc         = CRC_INIT;
    trk_count       = 0;
    trk_delay       = 16'h0000;
    trk_magic_bad   = 1'b0;
    trk_version_bad = 1'b0;
  endfunction

  // advance the tracker by one accepted byte; returns 1 when a result is due
  function automatic bit track_byte(input logic [7:0] b, input logic l,
                                    output frame_res_t r);
    int unsigned idx;
    logic [7:0]  prev;
    logic [15:0] trailer;
    int unsigned len;
    idx = trk_count;
    prev = trk_delay[7:0];
    r = NO_RES;
    if (idx >= 2) trk_crc = crc16_step(trk_crc, trk_delay[15:8]);
    trk_delay = {trk_delay[7:0], b};
    if (idx < 4) begin
      if (b != cfg_magic[8*idx +: 8]) trk_magic_bad = 1'b1;
    end else if (idx == 4) begin
      if (b != cfg_version) trk_version_bad = 1'b1;
    end
    if (trk_count < FRM_MAX + 1) trk_count++;
    if (!l) return 1'b0;
    len = trk_count;
    trailer = {b, prev};
    if (len < HDR_LEN + 2) begin
      r.status = ST_TOO_SHORT;
    end else if (len > FRM_MAX) begin
      r.status = ST_TOO_LONG;
    end else begin
      r.plen = (len - HDR_LEN - 2 > 255) ? 8'd255 : 8'(len - HDR_LEN - 2);
      if (trk_magic_bad)            r.status = ST_BAD_MAGIC;
      else if (trk_version_bad)     r.status = ST_BAD_VERSION;
      else if (trk_crc != trailer)  r.status = ST_BAD_CRC;
      else                          r.status = ST_OK;
    end
    r.crc = trk_crc;
    clear_frame();
    return 1'b1;
  endfunction

  // offer one item after a random gap; record its expected result on accept
  task automatic send_item(input logic [7:0] b, input logic l,
                           input bit typed, input frame_res_t typed_res);
    int unsigned gap;
    frame_res_t  r;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_i      <= l;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (track_byte(b, l, r)) begin
      pending_res.push_back(typed ? typed_res : r);
      frames_sent++;
    end
  endtask

  // stop sending, wait for every result, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup, access, then return to idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MAGIC) cfg_magic = value;
    else                  cfg_version = value[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stalls, compare each popped result
  initial begin : rx_side
    int unsigned stall;
    frame_res_t  want;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      results_seen++;
      if (status_o < 6) status_seen[status_o]++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d len %0d crc %h",
                 $time, status_o, data_len_o, crc_computed_o);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, status_o);
          errors++;
        end
        if (data_len_o !== want.plen) begin
          $display("%0t: data_len mismatch, expected %0d, got %0d",
                   $time, want.plen, data_len_o);
          errors++;
        end
        if (crc_computed_o !== want.crc) begin
          $display("%0t: crc_computed mismatch, expected %h, got %h",
                   $time, want.crc, crc_computed_o);
          errors++;
        end
      end
    end
  end

  // main sequence
  initial begin : tx_side
    logic [7:0]  frame_q [$];
    logic [15:0] fcs;
    int unsigned sel;
    int unsigned kind;
    int unsigned flen;
    int unsigned pos;
    int          phase;
    int          nfrm;
    errors        = 0;
    items_sent    = 0;
    frames_sent   = 0;
    results_seen  = 0;
    settings_used = 1;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    foreach (status_seen[s]) status_seen[s] = 0;
    cfg_magic   = 32'h0;
    cfg_version = 8'h0;
    clear_frame();
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    data_byte_i <= 8'h00;
    last_i      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= 3'd0;
    pwdata      <= 32'h0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, each with its own register setting
    phase = 0;
    while (items_sent < N_ITEMS) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_MAGIC, 32'hFFFF_FFFF);
          write_reg(REG_VERSION, 32'h0000_00FF);
        end
        2: begin
          write_reg(REG_MAGIC, 32'h0);
          write_reg(REG_VERSION, 32'h0);
        end
        default: begin
          write_reg(REG_MAGIC, $urandom());
          write_reg(REG_VERSION, $urandom());
        end
      endcase
      settings_used++;
      for (nfrm = 0; nfrm < 6 && items_sent < N_ITEMS; nfrm++) begin
        tx_burst = ($urandom_range(0, 4) == 0);
        rx_burst = ($urandom_range(0, 4) == 0);
        // length: mostly small valid frames, a few large, short and overlong
        sel = $urandom_range(0, 99);
        if (sel < 8)       flen = $urandom_range(1, HDR_LEN + 1);
        else if (sel < 11) flen = $urandom_range(FRM_MAX + 1, FRM_MAX + 20);
        else if (sel < 16) flen = $urandom_range(100, FRM_MAX);
        else               flen = $urandom_range(HDR_LEN + 2, HDR_LEN + 32);
        frame_q.delete();
        repeat (flen) frame_q.push_back(8'($urandom()));
        kind = $urandom_range(0, 99);
        if (kind < 88 && flen >= 6) begin
          // well-formed header and trailer
          for (pos = 0; pos < 4; pos++) frame_q[pos] = cfg_magic[8*pos +: 8];
          frame_q[4] = cfg_version;
          fcs = CRC_INIT;
          for (pos = 0; pos < flen - 2; pos++) fcs = crc16_step(fcs, frame_q[pos]);
          frame_q[flen-2] = fcs[7:0];
          frame_q[flen-1] = fcs[15:8];
          // for the damaged kinds, damage one part of it
          if (kind >= 65 && kind < 75) begin
            frame_q[flen - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
          end else if (kind >= 75 && kind < 82) begin
            frame_q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
          end else if (kind >= 82) begin
            frame_q[4] ^= 8'(1 << $urandom_range(0, 7));
          end
        end
        for (pos = 0; pos < flen; pos++) begin
          send_item(frame_q[pos], pos == flen - 1, 1'b0, NO_RES);
        end
      end
      phase++;
    end

    tx_burst = 1'b0;
    rx_burst = 1'b0;
    drain();
    $display("Sent %0d items in %0d frames over %0d register settings, checked %0d results",
             items_sent, frames_sent, settings_used, results_seen);
    $display("Status mix: ok %0d, short %0d, long %0d, magic %0d, version %0d, crc %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
